### rtl/voice_pitch_gain_setup_top_assert.svh
// Assertion macros for the voice pitch and gain setup block.
// Used by the port-level checker; depends on nothing else.
`ifndef VOICE_PITCH_GAIN_SETUP_TOP_ASSERT_SVH
`define VOICE_PITCH_GAIN_SETUP_TOP_ASSERT_SVH

// Property checked only while out of reset.
`define VPGS_CHECK(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("vpgs check failed");

// Property checked at every edge, reset included.
`define VPGS_CHECK_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("vpgs check failed");

`endif

### rtl/vpgs_pkg.sv
// Shared types and constants of the voice pitch and gain setup block.
// Depends on nothing; used by every module of the block.
package vpgs_pkg;

  localparam int VOICE_W  = 6;
  localparam int GAIN_W   = 10;
  localparam int MIX_W    = 19;
  localparam int PROD_W   = 49;          // 31-bit pitch times 18-bit C5 rate
  localparam int FREQ_FRAC = 8;
  localparam int DIV1_W   = PROD_W + FREQ_FRAC;
  localparam int Q1_W     = 41;          // quotient bits of the C5 divide
  // The C5 reference 66976 is 2^5 times 2093; the power of two is a plain shift.
  localparam int C5_POW2  = 5;
  localparam logic [11:0] C5_ODD = 12'd2093;
  localparam int NUM1_W   = DIV1_W - C5_POW2;
  localparam int DIG_W    = 13;          // quotient digit per reciprocal step
  localparam int DIGITS   = 4;           // NUM1_W / DIG_W
  localparam int REM1_W   = 12;
  localparam int PART_W   = REM1_W + DIG_W;
  localparam int RCP_W    = 26;
  localparam int RCP_SHIFT = PART_W + 12;
  // ceil(2^37 / 2093): exact quotient for every partial dividend below 2^25.
  localparam logic [RCP_W-1:0] C5_RCP = 26'd65666008;
  localparam int DIV2_W   = Q1_W + 5;    // 2^MIX_FRAC / 2^FREQ_FRAC = 32
  localparam int Q2_W     = 31;
  localparam int PANMAX   = 255;
  localparam logic [15:0] DECLICK_LEVEL = 16'd512;

  typedef enum logic [1:0] {
    CFG_MIX_RATE    = 2'd0,
    CFG_GLOBAL_GAIN = 2'd1,
    CFG_STEREO_MODE = 2'd2,
    CFG_UNUSED      = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [VOICE_W-1:0]       voice;
    logic                     rev;
    logic                     first;
    logic                     ramp;
    logic                     pos;
    logic                     ovf;
    logic signed [GAIN_W-1:0] gl;
    logic signed [GAIN_W-1:0] gr;
  } item_t;

endpackage

### rtl/voice_pitch_gain_setup_top.sv
// Top level of the voice pitch and gain setup block.
// Depends on vpgs_pkg, vpgs_div_c5, vpgs_div_mix and vpgs_gain_store.
//
// One voice update request is taken in every clock cycle (busy is always low) and
// its result appears as a one-cycle out_strobe pulse. The receiver cannot stall,
// so results must be captured on the cycle they appear. A request passes through
// the two pipelined divisions: 8 stages dividing by the
// C5 reference (a reciprocal multiply and a remainder step for each of four
// 13-bit digits), one overflow-check stage and 31 stages dividing by the mixing
// rate, plus an input stage holding the pitch product and an output stage where
// the per-voice gain memory is read. Configuration must only be written while no
// request is in flight.
module voice_pitch_gain_setup_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [5:0]         in_voice_number,
  input  logic signed [31:0] in_pitch,
  input  logic [17:0]        in_sample_c5_rate,
  input  logic               in_reverse,
  input  logic [7:0]         in_voice_gain,
  input  logic [7:0]         in_pan_position,
  input  logic               in_surround,
  input  logic               in_first_update,
  input  logic signed [15:0] in_start_sample,
  output logic               out_strobe,
  output logic               out_voice_active,
  output logic signed [31:0] out_phase_step,
  output logic signed [9:0]  out_left_gain,
  output logic signed [9:0]  out_right_gain,
  output logic signed [9:0]  out_prior_left_gain,
  output logic signed [9:0]  out_prior_right_gain,
  output logic               out_ramp_first,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [18:0]        cfg_wdata
);
  import vpgs_pkg::*;

  // Configuration registers.
  logic [MIX_W-1:0] mix_rate_r;
  logic [7:0]       global_gain_r;
  logic             stereo_mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mix_rate_r    <= MIX_W'(44100);
      global_gain_r <= 8'd127;
      stereo_mode_r <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_MIX_RATE:    mix_rate_r    <= cfg_wdata;
        CFG_GLOBAL_GAIN: global_gain_r <= cfg_wdata[7:0];
        CFG_STEREO_MODE: stereo_mode_r <= cfg_wdata[0];
        CFG_UNUSED:      ;
      endcase
    end
  end

  assign busy = 1'b0;

  // Input stage: gains, declick flag and the pitch times C5 rate product.
  logic          accept;
  logic [15:0]   vol_prod;
  logic [8:0]    vol;
  logic [16:0]   left_prod;
  logic [16:0]   right_prod;
  logic [7:0]    half_vol;
  logic [15:0]   abs_smp;
  item_t         item_nxt;
  logic          s0_valid_r;
  item_t         s0_item_r;
  logic [PROD_W-1:0] s0_prod_r;

  assign accept     = start && !busy;
  assign vol_prod   = in_voice_gain * global_gain_r;
  assign vol        = vol_prod[15:7];
  assign left_prod  = vol * (8'(PANMAX) - in_pan_position);
  assign right_prod = vol * in_pan_position;
  assign half_vol   = vol[8:1];
  assign abs_smp    = in_start_sample[15] ? (16'd0 - in_start_sample) : in_start_sample;

  always_comb begin
    item_nxt       = '0;
    item_nxt.voice = in_voice_number;
    item_nxt.rev   = in_reverse;
    item_nxt.first = in_first_update;
    item_nxt.ramp  = in_first_update && (abs_smp > DECLICK_LEVEL);
    item_nxt.pos   = !in_pitch[31] && (in_pitch != 32'sd0);
    if (!stereo_mode_r) begin
      item_nxt.gl = {1'b0, vol};
      item_nxt.gr = '0;
    end else if (in_surround) begin
      item_nxt.gl = {2'b00, half_vol};
      item_nxt.gr = GAIN_W'(10'd0 - {2'b00, half_vol});
    end else begin
      item_nxt.gl = {1'b0, left_prod[16:8]};
      item_nxt.gr = {1'b0, right_prod[16:8]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else begin
      s0_valid_r <= accept;
    end
    s0_item_r <= item_nxt;
    s0_prod_r <= in_pitch[30:0] * in_sample_c5_rate;
  end

  // The two divisions.
  logic              d1_valid;
  item_t             d1_item;
  logic [Q1_W-1:0]   d1_quot;
  logic              d2_valid;
  item_t             d2_item;
  logic [Q2_W-1:0]   d2_quot;

  vpgs_div_c5 u_div_c5 (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (s0_valid_r),
    .in_item     (s0_item_r),
    .in_dividend ({s0_prod_r, {FREQ_FRAC{1'b0}}}),
    .out_valid   (d1_valid),
    .out_item    (d1_item),
    .out_quot    (d1_quot)
  );

  vpgs_div_mix u_div_mix (
    .clk         (clk),
    .rst_n       (rst_n),
    .mix_rate    (mix_rate_r),
    .in_valid    (d1_valid),
    .in_item     (d1_item),
    .in_dividend ({d1_quot, 5'b00000}),
    .out_valid   (d2_valid),
    .out_item    (d2_item),
    .out_quot    (d2_quot)
  );

  // Saturation, direction and the active decision.
  logic signed [31:0] step_nxt;
  logic               active_nxt;
  logic               out_valid_r;
  item_t              out_item_r;
  logic signed [31:0] out_step_r;
  logic               out_active_r;

  always_comb begin
    if (d2_item.ovf) begin
      step_nxt = d2_item.rev ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      step_nxt = d2_item.rev ? (32'sd0 - {1'b0, d2_quot}) : {1'b0, d2_quot};
    end
    active_nxt = d2_item.pos && (d2_item.ovf || (d2_quot != '0));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= d2_valid;
    end
    out_item_r   <= d2_item;
    out_step_r   <= step_nxt;
    out_active_r <= active_nxt;
  end

  // Gain memory: read as the result enters the output stage, written back when an active result leaves.
  logic [2*GAIN_W-1:0] stored;
  logic                wr_en;

  assign wr_en = out_valid_r && out_active_r;

  vpgs_gain_store u_gain_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (d2_valid),
    .rd_addr (d2_item.voice),
    .wr_en   (wr_en),
    .wr_addr (out_item_r.voice),
    .wr_data ({out_item_r.gr, out_item_r.gl}),
    .rd_data (stored)
  );

  // An inactive voice reports all fields as zero.
  always_comb begin
    out_strobe       = out_valid_r;
    out_voice_active = out_active_r;
    out_phase_step   = '0;
    out_left_gain    = '0;
    out_right_gain   = '0;
    out_prior_left_gain  = '0;
    out_prior_right_gain = '0;
    out_ramp_first   = 1'b0;
    if (out_active_r) begin
      out_phase_step = out_step_r;
      out_left_gain  = out_item_r.gl;
      out_right_gain = out_item_r.gr;
      out_ramp_first = out_item_r.ramp;
      if (out_item_r.first) begin
        out_prior_left_gain  = out_item_r.gl;
        out_prior_right_gain = out_item_r.gr;
      end else begin
        out_prior_left_gain  = stored[GAIN_W-1:0];
        out_prior_right_gain = stored[2*GAIN_W-1:GAIN_W];
      end
    end
  end

endmodule

### rtl/vpgs_div_c5.sv
// Pipelined divider by the constant C5 reference: reciprocal multiplication on
// 13-bit digits, two stages per digit. Depends on vpgs_pkg.
module vpgs_div_c5 (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  vpgs_pkg::item_t             in_item,
  input  logic [vpgs_pkg::DIV1_W-1:0] in_dividend,
  output logic                        out_valid,
  output vpgs_pkg::item_t             out_item,
  output logic [vpgs_pkg::Q1_W-1:0]   out_quot
);
  import vpgs_pkg::*;

  logic [NUM1_W-1:0]       num;
  logic [DIGITS-1:0]       a_valid_r;
  item_t                   a_item_r  [DIGITS];
  logic [PART_W-1:0]       a_part_r  [DIGITS];
  logic [DIG_W-1:0]        a_qd_r    [DIGITS];
  logic [NUM1_W-1:0]       a_low_r   [DIGITS];
  logic [NUM1_W-1:0]       a_quot_r  [DIGITS];
  logic [DIGITS-1:0]       b_valid_r;
  item_t                   b_item_r  [DIGITS];
  logic [REM1_W-1:0]       b_rem_r   [DIGITS];
  logic [NUM1_W-1:0]       b_low_r   [DIGITS];
  logic [NUM1_W-1:0]       b_quot_r  [DIGITS];
  logic [DIGITS-1:0]       src_valid;
  item_t                   src_item  [DIGITS];
  logic [REM1_W-1:0]       src_rem   [DIGITS];
  logic [NUM1_W-1:0]       src_low   [DIGITS];
  logic [NUM1_W-1:0]       src_quot  [DIGITS];
  logic [PART_W-1:0]       part      [DIGITS];
  logic [PART_W+RCP_W-1:0] rcp_prod  [DIGITS];
  logic [DIG_W-1:0]        qd        [DIGITS];
  logic [PART_W-1:0]       back_prod [DIGITS];
  logic [REM1_W-1:0]       rem_nxt   [DIGITS];

  // Dropping the power-of-two factor first keeps the floor exact.
  assign num = in_dividend[DIV1_W-1:C5_POW2];

  always_comb begin
    src_valid[0] = in_valid;
    src_item[0]  = in_item;
    src_rem[0]   = '0;
    src_low[0]   = num;
    src_quot[0]  = '0;
    for (int d = 1; d < DIGITS; d++) begin
      src_valid[d] = b_valid_r[d-1];
      src_item[d]  = b_item_r[d-1];
      src_rem[d]   = b_rem_r[d-1];
      src_low[d]   = b_low_r[d-1];
      src_quot[d]  = b_quot_r[d-1];
    end
    for (int d = 0; d < DIGITS; d++) begin
      // First stage of a digit: quotient digit from the reciprocal.
      part[d]      = {src_rem[d], src_low[d][NUM1_W-1 -: DIG_W]};
      rcp_prod[d]  = part[d] * C5_RCP;
      qd[d]        = rcp_prod[d][RCP_SHIFT +: DIG_W];
      // Second stage: the remainder carried into the next digit.
      back_prod[d] = a_qd_r[d] * C5_ODD;
      rem_nxt[d]   = REM1_W'(a_part_r[d] - back_prod[d]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= '0;
      b_valid_r <= '0;
    end else begin
      a_valid_r <= src_valid;
      b_valid_r <= a_valid_r;
    end
    for (int d = 0; d < DIGITS; d++) begin
      a_item_r[d] <= src_item[d];
      a_part_r[d] <= part[d];
      a_qd_r[d]   <= qd[d];
      a_low_r[d]  <= src_low[d] << DIG_W;
      a_quot_r[d] <= {src_quot[d][NUM1_W-DIG_W-1:0], qd[d]};
      b_item_r[d] <= a_item_r[d];
      b_rem_r[d]  <= rem_nxt[d];
      b_low_r[d]  <= a_low_r[d];
      b_quot_r[d] <= a_quot_r[d];
    end
  end

  assign out_valid = b_valid_r[DIGITS-1];
  assign out_item  = b_item_r[DIGITS-1];
  assign out_quot  = b_quot_r[DIGITS-1][Q1_W-1:0];

endmodule

### rtl/vpgs_div_mix.sv
// Pipelined restoring divider by the mixing rate with early overflow detection.
// Depends on vpgs_pkg.
module vpgs_div_mix (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [vpgs_pkg::MIX_W-1:0]  mix_rate,
  input  logic                        in_valid,
  input  vpgs_pkg::item_t             in_item,
  input  logic [vpgs_pkg::DIV2_W-1:0] in_dividend,
  output logic                        out_valid,
  output vpgs_pkg::item_t             out_item,
  output logic [vpgs_pkg::Q2_W-1:0]   out_quot
);
  import vpgs_pkg::*;

  logic [MIX_W-1:0] divisor;
  logic [MIX_W-1:0] top_bits;
  logic             ld_ovf;
  item_t            ld_item;

  logic [Q2_W:0]    valid_r;
  item_t            item_r [Q2_W+1];
  logic [MIX_W-1:0] rem_r  [Q2_W+1];
  logic [Q2_W-1:0]  low_r  [Q2_W+1];
  logic [MIX_W-1:0] rem_nxt [Q2_W];
  logic [Q2_W-1:0]  low_nxt [Q2_W];
  logic [MIX_W:0]   trial   [Q2_W];

  // A zero rate is taken as one.
  assign divisor  = (mix_rate == '0) ? MIX_W'(1) : mix_rate;
  assign top_bits = MIX_W'(in_dividend[DIV2_W-1:Q2_W]);
  assign ld_ovf   = (top_bits >= divisor);

  always_comb begin
    ld_item     = in_item;
    ld_item.ovf = ld_ovf;
  end

  always_comb begin
    for (int s = 0; s < Q2_W; s++) begin
      trial[s] = {rem_r[s], low_r[s][Q2_W-1]};
      if (trial[s] >= {1'b0, divisor}) begin
        rem_nxt[s] = MIX_W'(trial[s] - {1'b0, divisor});
        low_nxt[s] = {low_r[s][Q2_W-2:0], 1'b1};
      end else begin
        rem_nxt[s] = trial[s][MIX_W-1:0];
        low_nxt[s] = {low_r[s][Q2_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= {valid_r[Q2_W-1:0], in_valid};
    end
    item_r[0] <= ld_item;
    rem_r[0]  <= ld_ovf ? '0 : top_bits;
    low_r[0]  <= in_dividend[Q2_W-1:0];
    for (int s = 0; s < Q2_W; s++) begin
      item_r[s+1] <= item_r[s];
      rem_r[s+1]  <= rem_nxt[s];
      low_r[s+1]  <= low_nxt[s];
    end
  end

  assign out_valid = valid_r[Q2_W];
  assign out_item  = item_r[Q2_W];
  assign out_quot  = low_r[Q2_W];

endmodule

### rtl/vpgs_gain_store.sv
// Per-voice gain memory with registered read data and write-to-read forwarding.
// Depends on vpgs_pkg.
module vpgs_gain_store (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          rd_en,
  input  logic [vpgs_pkg::VOICE_W-1:0]  rd_addr,
  input  logic                          wr_en,
  input  logic [vpgs_pkg::VOICE_W-1:0]  wr_addr,
  input  logic [2*vpgs_pkg::GAIN_W-1:0] wr_data,
  output logic [2*vpgs_pkg::GAIN_W-1:0] rd_data
);
  import vpgs_pkg::*;

  logic [2*GAIN_W-1:0] mem [2**VOICE_W];
  logic [2*GAIN_W-1:0] rdata_r;
  logic [2*GAIN_W-1:0] fwd_data_r;
  logic                fwd_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
    fwd_data_r <= wr_data;
  end

  // A write in the same cycle as a read of that entry bypasses the memory.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r <= 1'b0;
    end else begin
      fwd_r <= wr_en && rd_en && (wr_addr == rd_addr);
    end
  end

  assign rd_data = fwd_r ? fwd_data_r : rdata_r;

endmodule

### rtl/vpgs_checker.sv
// Port-level checker for the voice pitch and gain setup block, with its bind.
// Depends on voice_pitch_gain_setup_top_assert.svh.
`include "voice_pitch_gain_setup_top_assert.svh"

module vpgs_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               busy,
  input logic               out_strobe,
  input logic               out_voice_active,
  input logic signed [31:0] out_phase_step,
  input logic signed [9:0]  out_left_gain,
  input logic signed [9:0]  out_right_gain,
  input logic signed [9:0]  out_prior_left_gain,
  input logic signed [9:0]  out_prior_right_gain,
  input logic               out_ramp_first
);

  logic fields_zero;

  assign fields_zero = (out_phase_step == 32'sd0) && (out_left_gain == 10'sd0) &&
                       (out_right_gain == 10'sd0) && (out_prior_left_gain == 10'sd0) &&
                       (out_prior_right_gain == 10'sd0) && !out_ramp_first;

  `VPGS_CHECK_ALWAYS(a_reset_quiet, !rst_n |=> !out_strobe)
  `VPGS_CHECK(a_never_busy, !busy)
  `VPGS_CHECK(a_active_moves, out_strobe && out_voice_active |-> out_phase_step != 32'sd0)
  `VPGS_CHECK(a_inactive_zero, out_strobe && !out_voice_active |-> fields_zero)

endmodule

bind voice_pitch_gain_setup_top vpgs_checker u_vpgs_checker (.*);
